// ===== hw/rtl/bpwm_pkg.sv =====
// Shared types and constants for the busy pin wait monitor.
package bpwm_pkg;

   localparam int CountWidthDefault = 16;

   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 16;
   localparam int MS_WIDTH        = 16;

   // Register indexes on the csr port
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_POLARITY_MODE  = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HOOK_THRESHOLD = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TOTAL_TIMEOUT  = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_START_WINDOW   = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PHASE_ONE_LIM  = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BEGIN_HOOK_EN  = 3'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_END_HOOK_EN    = 3'd6;

   // Polarity modes; the unused code behaves as two-phase
   localparam logic [1:0] MODE_ACTIVE_HIGH = 2'd0;
   localparam logic [1:0] MODE_ACTIVE_LOW  = 2'd1;
   localparam logic [1:0] MODE_TWO_PHASE   = 2'd2;

   // Result codes
   localparam logic [1:0] RES_COMPLETED = 2'd0;
   localparam logic [1:0] RES_NEVER     = 2'd1;
   localparam logic [1:0] RES_TIMEOUT   = 2'd2;

   // Register reset values
   localparam logic [1:0]          POLARITY_RESET      = 2'd0;
   localparam logic [MS_WIDTH-1:0] HOOK_THRESHOLD_RESET = 16'd1000;
   localparam logic [MS_WIDTH-1:0] TOTAL_TIMEOUT_RESET  = 16'd30000;
   localparam logic [MS_WIDTH-1:0] START_WINDOW_RESET   = 16'd100;
   localparam logic [MS_WIDTH-1:0] PHASE_ONE_LIM_RESET  = 16'd1000;

   typedef struct packed {
      logic start_wait;
      logic busy_level;
   } req_payload_type;

   typedef struct packed {
      logic       wait_done;
      logic [1:0] result_code;
      logic       hook_begin;
      logic       hook_end;
      logic       waiting;
   } rsp_payload_type;

endpackage

// ===== hw/rtl/bpwm_stream_if.sv =====
// Valid/ready stream interface carrying one payload per transaction.
interface bpwm_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/busy_pin_wait_monitor_core.sv =====
// Busy pin wait monitor: phase machine, elapsed counter and hook pulses.
//
// Usage: each req_stream transaction is one millisecond tick carrying
// start_wait and the sampled busy_level. Every accepted tick yields exactly
// one rsp_stream transaction with wait_done, result_code, hook_begin,
// hook_end and waiting. Configuration is written through csr_we/csr_index/
// csr_wdata while no tick is in flight; polarity is sampled on the start tick,
// the other registers are read live.
// Output: the result is registered and reaches rsp_stream in the cycle after
// the tick is accepted. Throughput: one tick per cycle unless a held result
// stalls it; phase, counter and result are computed in the same cycle.
// Stall: the result register holds while rsp_stream.ready is low; a new tick
// is taken in the cycle the held result leaves, so req_stream.ready follows
// rsp_stream.ready when a result is pending.
// Reset (synchronous, active high): monitor goes idle, counter clears, the
// result register empties and registers return to their defaults.
module busy_pin_wait_monitor_core #(
   parameter int COUNT_WIDTH = bpwm_pkg::CountWidthDefault
) (
   input  logic                                 clock,
   input  logic                                 reset,
   bpwm_stream_if.sink                          req_stream,
   bpwm_stream_if.source                        rsp_stream,
   input  logic                                 csr_we,
   input  logic [bpwm_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [bpwm_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);
   import bpwm_pkg::*;

   localparam int CMP_WIDTH = (COUNT_WIDTH > MS_WIDTH) ? COUNT_WIDTH : MS_WIDTH;

   localparam logic [2:0] PH_IDLE      = 3'd0;
   localparam logic [2:0] PH_AH        = 3'd1;
   localparam logic [2:0] PH_AL_WINDOW = 3'd2;
   localparam logic [2:0] PH_AL_BUSY   = 3'd3;
   localparam logic [2:0] PH_TP_ONE    = 3'd4;
   localparam logic [2:0] PH_TP_TWO    = 3'd5;

   // Configuration registers
   logic [1:0]          polarity_mode_ff;
   logic [MS_WIDTH-1:0] hook_threshold_ff;
   logic [MS_WIDTH-1:0] total_timeout_ff;
   logic [MS_WIDTH-1:0] start_window_ff;
   logic [MS_WIDTH-1:0] phase_one_lim_ff;
   logic                begin_hook_en_ff;
   logic                end_hook_en_ff;

   // Wait state
   logic [2:0]             phase_ff, phase_in;
   logic [COUNT_WIDTH-1:0] elapsed_ff, elapsed_in;
   logic                   long_seen_ff, long_seen_in;
   logic                   fired_ff, fired_in;

   // Result register
   logic            rsp_valid_ff;
   rsp_payload_type rsp_payload_ff, rsp_payload_in;

   logic accept;
   logic start, high;
   logic [2:0] phase_cur;
   logic [CMP_WIDTH-1:0] e_cmp;
   logic run_chk, timeout, finish;
   logic [1:0] code;
   logic hb;

   assign req_stream.ready   = !rsp_valid_ff || rsp_stream.ready;
   assign accept             = req_stream.valid && req_stream.ready;
   assign rsp_stream.valid   = rsp_valid_ff;
   assign rsp_stream.payload = rsp_payload_ff;

   assign start = req_stream.payload.start_wait;
   assign high  = req_stream.payload.busy_level;

   always_comb begin
      phase_cur    = phase_ff;
      elapsed_in   = elapsed_ff;
      long_seen_in = long_seen_ff;
      fired_in     = fired_ff;
      if (start) begin
         elapsed_in   = '0;
         long_seen_in = 1'b0;
         fired_in     = 1'b0;
         case (polarity_mode_ff)
            MODE_ACTIVE_HIGH: phase_cur = PH_AH;
            MODE_ACTIVE_LOW:  phase_cur = PH_AL_WINDOW;
            default:          phase_cur = PH_TP_ONE;
         endcase
      end else if (phase_ff != PH_IDLE && elapsed_ff != {COUNT_WIDTH{1'b1}}) begin
         elapsed_in = elapsed_ff + 1'b1;
      end
      e_cmp = CMP_WIDTH'(elapsed_in);

      phase_in = phase_cur;
      run_chk  = 1'b0;
      finish   = 1'b0;
      code     = RES_COMPLETED;
      case (phase_cur)
         PH_AH, PH_AL_BUSY, PH_TP_TWO: begin
            if ((phase_cur == PH_AH) ? high : !high) begin
               run_chk = 1'b1;
            end else begin
               finish = 1'b1;
            end
         end
         PH_AL_WINDOW: begin
            if (!high && (start || e_cmp < CMP_WIDTH'(start_window_ff))) begin
               phase_in = PH_AL_BUSY;
               run_chk  = 1'b1;
            end else if (e_cmp >= CMP_WIDTH'(start_window_ff)) begin
               finish = 1'b1;
            end
         end
         PH_TP_ONE: begin
            if (!high) begin
               phase_in = PH_TP_TWO;
               run_chk  = 1'b1;
            end else if (e_cmp > CMP_WIDTH'(phase_one_lim_ff)) begin
               finish = 1'b1;
               code   = RES_NEVER;
            end
         end
         default: phase_in = PH_IDLE;
      endcase

      // Long-wait check, then total timeout
      hb      = 1'b0;
      timeout = run_chk && (e_cmp > CMP_WIDTH'(total_timeout_ff));
      if (run_chk && !long_seen_in && e_cmp > CMP_WIDTH'(hook_threshold_ff)) begin
         long_seen_in = 1'b1;
         if (begin_hook_en_ff) begin
            fired_in = 1'b1;
            hb       = 1'b1;
         end
      end
      if (timeout) begin
         finish = 1'b1;
         code   = RES_TIMEOUT;
      end
      if (finish) begin
         phase_in = PH_IDLE;
      end

      rsp_payload_in.wait_done   = finish;
      rsp_payload_in.result_code = code;
      rsp_payload_in.hook_begin  = hb;
      rsp_payload_in.hook_end    = finish && fired_in && end_hook_en_ff;
      rsp_payload_in.waiting     = (phase_in != PH_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         elapsed_ff   <= '0;
         long_seen_ff <= 1'b0;
         fired_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff     <= phase_in;
            elapsed_ff   <= elapsed_in;
            long_seen_ff <= long_seen_in;
            fired_ff     <= fired_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_stream.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         polarity_mode_ff  <= POLARITY_RESET;
         hook_threshold_ff <= HOOK_THRESHOLD_RESET;
         total_timeout_ff  <= TOTAL_TIMEOUT_RESET;
         start_window_ff   <= START_WINDOW_RESET;
         phase_one_lim_ff  <= PHASE_ONE_LIM_RESET;
         begin_hook_en_ff  <= 1'b0;
         end_hook_en_ff    <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_POLARITY_MODE:  polarity_mode_ff  <= csr_wdata[1:0];
            CSR_HOOK_THRESHOLD: hook_threshold_ff <= csr_wdata[MS_WIDTH-1:0];
            CSR_TOTAL_TIMEOUT:  total_timeout_ff  <= csr_wdata[MS_WIDTH-1:0];
            CSR_START_WINDOW:   start_window_ff   <= csr_wdata[MS_WIDTH-1:0];
            CSR_PHASE_ONE_LIM:  phase_one_lim_ff  <= csr_wdata[MS_WIDTH-1:0];
            CSR_BEGIN_HOOK_EN:  begin_hook_en_ff  <= csr_wdata[0];
            CSR_END_HOOK_EN:    end_hook_en_ff    <= csr_wdata[0];
            default: ;
         endcase
      end
   end

`ifndef SYNTHESIS
   a_accept_gives_result: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted tick produced no result");

   a_waiting_matches_phase: assert property (@(posedge clock) disable iff (reset)
      accept |=> (rsp_payload_ff.waiting == (phase_ff != PH_IDLE)))
      else $error("waiting flag disagrees with phase");

   a_end_hook_at_finish: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_payload_ff.hook_end) |-> rsp_payload_ff.wait_done)
      else $error("end hook without finish");

   a_code_only_at_finish: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_payload_ff.result_code != RES_COMPLETED)
         |-> rsp_payload_ff.wait_done)
      else $error("result code set without finish");

   a_fired_implies_long: assert property (@(posedge clock) disable iff (reset)
      fired_ff |-> long_seen_ff)
      else $error("begin hook fired without long wait");
`endif

endmodule

// ===== test/busy_pin_wait_monitor_core_test.sv =====
// Self-checking testbench for the busy pin wait monitor core: directed table, random ticks.
module busy_pin_wait_monitor_core_test;
   import bpwm_pkg::*;

   localparam logic [1:0] MODE_CODE_THREE  = 2'd3;

   localparam int WATCHDOG_LIMIT = 5000;

   typedef enum logic [2:0] {
      W_IDLE, W_HIGH, W_LOW_WINDOW, W_LOW_BUSY, W_PHASE_ONE, W_PHASE_TWO
   } wait_phase_type;

   typedef enum logic {ROW_TICK, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type               kind;
      logic [CSR_INDEX_WIDTH-1:0] csr_idx;
      logic [CSR_DATA_WIDTH-1:0]  csr_data;
      logic                       start_wait;
      logic                       busy_level;
      logic                       pinned;
      rsp_payload_type            want;
   } stim_row_type;

   localparam rsp_payload_type RSP_QUIET   = '{1'b0, RES_COMPLETED, 1'b0, 1'b0, 1'b0};
   localparam rsp_payload_type RSP_WAITING = '{1'b0, RES_COMPLETED, 1'b0, 1'b0, 1'b1};
   localparam rsp_payload_type RSP_DONE_OK = '{1'b1, RES_COMPLETED, 1'b0, 1'b0, 1'b0};
   localparam rsp_payload_type RSP_DONE_OK_HOOK = '{1'b1, RES_COMPLETED, 1'b0, 1'b1, 1'b0};
   localparam rsp_payload_type RSP_TIMEOUT_HOOKS = '{1'b1, RES_TIMEOUT, 1'b1, 1'b1, 1'b0};
   localparam rsp_payload_type RSP_NEVER = '{1'b1, RES_NEVER, 1'b0, 1'b0, 1'b0};

   localparam stim_row_type DIRECTED_ROWS [37] = '{
      // idle ticks, then plain active-high waits with defaults
      '{ROW_TICK, '0, '0, 1'b0, 1'b1, 1'b1, RSP_QUIET},
      '{ROW_TICK, '0, '0, 1'b0, 1'b0, 1'b1, RSP_QUIET},
      '{ROW_TICK, '0, '0, 1'b1, 1'b0, 1'b1, RSP_DONE_OK},
      '{ROW_TICK, '0, '0, 1'b1, 1'b1, 1'b1, RSP_WAITING},
      '{ROW_TICK, '0, '0, 1'b0, 1'b1, 1'b1, RSP_WAITING},
      '{ROW_TICK, '0, '0, 1'b1, 1'b1, 1'b1, RSP_WAITING},
      '{ROW_TICK, '0, '0, 1'b0, 1'b0, 1'b1, RSP_DONE_OK},
      // begin hook and timeout on the same tick
      '{ROW_CSR, CSR_BEGIN_HOOK_EN, 16'd1, 1'b0, 1'b0, 1'b0, RSP_QUIET},
      '{ROW_CSR, CSR_END_HOOK_EN, 16'd1, 1'b0, 1'b0, 1'b0, RSP_QUIET},
      '{ROW_CSR, CSR_HOOK_THRESHOLD, 16'd2, 1'b0, 1'b0, 1'b0, RSP_QUIET},
      '{ROW_CSR, CSR_TOTAL_TIMEOUT, 16'd2, 1'b0, 1'b0, 1'b0, RSP_QUIET},
      '{ROW_TICK, '0, '0, 1'b1, 1'b1, 1'b0, RSP_QUIET},
      '{ROW_TICK, '0, '0, 1'b0, 1'b1, 1'b0, RSP_QUIET},
      '{ROW_TICK, '0, '0, 1'b0, 1'b1, 1'b0, RSP_QUIET},
      '{ROW_TICK, '0, '0, 1'b0, 1'b1, 1'b1, RSP_TIMEOUT_HOOKS},
      // active-low: window expiry, then low on the start tick
      '{ROW_CSR, CSR_TOTAL_TIMEOUT, 16'hFFFF, 1'b0, 1'b0, 1'b0, RSP_QUIET},
      '{ROW_CSR, CSR_POLARITY_MODE, CSR_DATA_WIDTH'(MODE_ACTIVE_LOW), 1'b0, 1'b0, 1'b0,
        RSP_QUIET},
      '{ROW_CSR, CSR_START_WINDOW, 16'd2, 1'b0, 1'b0, 1'b0, RSP_QUIET},
      '{ROW_TICK, '0, '0, 1'b1, 1'b1, 1'b0, RSP_QUIET},
      '{ROW_TICK, '0, '0, 1'b0, 1'b1, 1'b0, RSP_QUIET},
      '{ROW_TICK, '0, '0, 1'b0, 1'b1, 1'b1, RSP_DONE_OK},
      '{ROW_TICK, '0, '0, 1'b1, 1'b0, 1'b0, RSP_QUIET},
      '{ROW_TICK, '0, '0, 1'b0, 1'b0, 1'b0, RSP_QUIET},
      '{ROW_TICK, '0, '0, 1'b0, 1'b0, 1'b0, RSP_QUIET},
      '{ROW_TICK, '0, '0, 1'b0, 1'b0, 1'b0, RSP_QUIET},
      '{ROW_TICK, '0, '0, 1'b0, 1'b1, 1'b1, RSP_DONE_OK_HOOK},
      // two-phase: never started, then low then high
      '{ROW_CSR, CSR_POLARITY_MODE, CSR_DATA_WIDTH'(MODE_TWO_PHASE), 1'b0, 1'b0, 1'b0,
        RSP_QUIET},
      '{ROW_CSR, CSR_PHASE_ONE_LIM, 16'd1, 1'b0, 1'b0, 1'b0, RSP_QUIET},
      '{ROW_TICK, '0, '0, 1'b1, 1'b1, 1'b0, RSP_QUIET},
      '{ROW_TICK, '0, '0, 1'b0, 1'b1, 1'b0, RSP_QUIET},
      '{ROW_TICK, '0, '0, 1'b0, 1'b1, 1'b1, RSP_NEVER},
      '{ROW_TICK, '0, '0, 1'b1, 1'b0, 1'b0, RSP_QUIET},
      '{ROW_TICK, '0, '0, 1'b0, 1'b1, 1'b0, RSP_QUIET},
      // polarity code three behaves as two-phase
      '{ROW_CSR, CSR_POLARITY_MODE, CSR_DATA_WIDTH'(MODE_CODE_THREE), 1'b0, 1'b0, 1'b0,
        RSP_QUIET},
      '{ROW_TICK, '0, '0, 1'b1, 1'b1, 1'b0, RSP_QUIET},
      '{ROW_TICK, '0, '0, 1'b0, 1'b0, 1'b0, RSP_QUIET},
      '{ROW_TICK, '0, '0, 1'b0, 1'b1, 1'b0, RSP_QUIET}
   };

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       csr_we = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata = '0;

   bpwm_stream_if #(.payload_type(req_payload_type)) req_if ();
   bpwm_stream_if #(.payload_type(rsp_payload_type)) rsp_if ();

   busy_pin_wait_monitor_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_stream (req_if),
      .rsp_stream (rsp_if),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // predictor copy of the registers and the wait state
   logic [1:0]          cfg_mode;
   logic [MS_WIDTH-1:0] cfg_threshold;
   logic [MS_WIDTH-1:0] cfg_timeout;
   logic [MS_WIDTH-1:0] cfg_window;
   logic [MS_WIDTH-1:0] cfg_limit;
   logic                cfg_begin_en;
   logic                cfg_end_en;
   wait_phase_type      phase;
   logic [15:0]         elapsed;
   logic                long_seen;
   logic                begin_fired;

   rsp_payload_type expected_q [$];
   int              fail_count = 0;
   int              idle_cycles = 0;
   int              send_idle_pct = 20;
   int              rcv_idle_pct = 79;
   logic            pin_active = 1'b0;
   rsp_payload_type pin_value = '0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      req_if.valid = 1'b0;
      req_if.payload = '0;
      rsp_if.ready = 1'b0;
   end

   always @(negedge clock) begin
      rsp_if.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
   end

   function automatic logic long_and_timeout(output logic pulse);
      pulse = 1'b0;
      if (!long_seen && elapsed > cfg_threshold) begin
         long_seen = 1'b1;
         if (cfg_begin_en) begin
            begin_fired = 1'b1;
            pulse = 1'b1;
         end
      end
      return elapsed > cfg_timeout;
   endfunction

   function automatic rsp_payload_type next_wait_result(input logic start, input logic level);
      rsp_payload_type r;
      logic            finish;
      logic            pulse;
      r = '0;
      finish = 1'b0;
      pulse = 1'b0;
      if (start) begin
         elapsed = '0;
         long_seen = 1'b0;
         begin_fired = 1'b0;
         case (cfg_mode)
            MODE_ACTIVE_HIGH: phase = W_HIGH;
            MODE_ACTIVE_LOW:  phase = W_LOW_WINDOW;
            default:          phase = W_PHASE_ONE;
         endcase
      end else if (phase != W_IDLE && elapsed != '1) begin
         elapsed = elapsed + 1'b1;
      end
      case (phase)
         W_HIGH, W_LOW_BUSY, W_PHASE_TWO: begin
            if ((phase == W_HIGH) ? level : !level) begin
               if (long_and_timeout(pulse)) begin
                  finish = 1'b1;
                  r.result_code = RES_TIMEOUT;
               end
            end else begin
               finish = 1'b1;
            end
         end
         W_LOW_WINDOW: begin
            if (!level && (start || elapsed < cfg_window)) begin
               phase = W_LOW_BUSY;
               if (long_and_timeout(pulse)) begin
                  finish = 1'b1;
                  r.result_code = RES_TIMEOUT;
               end
            end else if (elapsed >= cfg_window) begin
               finish = 1'b1;
            end
         end
         W_PHASE_ONE: begin
            if (!level) begin
               phase = W_PHASE_TWO;
               if (long_and_timeout(pulse)) begin
                  finish = 1'b1;
                  r.result_code = RES_TIMEOUT;
               end
            end else if (elapsed > cfg_limit) begin
               finish = 1'b1;
               r.result_code = RES_NEVER;
            end
         end
         default: phase = W_IDLE;
      endcase
      r.hook_begin = pulse;
      if (finish) begin
         r.wait_done = 1'b1;
         r.hook_end = begin_fired && cfg_end_en;
         phase = W_IDLE;
      end
      r.waiting = (phase != W_IDLE);
      return r;
   endfunction

   function automatic void check_field(string name, int want, int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_payload_type want;
      if (reset) begin
         cfg_mode = POLARITY_RESET;
         cfg_threshold = HOOK_THRESHOLD_RESET;
         cfg_timeout = TOTAL_TIMEOUT_RESET;
         cfg_window = START_WINDOW_RESET;
         cfg_limit = PHASE_ONE_LIM_RESET;
         cfg_begin_en = 1'b0;
         cfg_end_en = 1'b0;
         phase = W_IDLE;
         elapsed = '0;
         long_seen = 1'b0;
         begin_fired = 1'b0;
         expected_q.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_POLARITY_MODE:  cfg_mode = csr_wdata[1:0];
               CSR_HOOK_THRESHOLD: cfg_threshold = csr_wdata;
               CSR_TOTAL_TIMEOUT:  cfg_timeout = csr_wdata;
               CSR_START_WINDOW:   cfg_window = csr_wdata;
               CSR_PHASE_ONE_LIM:  cfg_limit = csr_wdata;
               CSR_BEGIN_HOOK_EN:  cfg_begin_en = csr_wdata[0];
               CSR_END_HOOK_EN:    cfg_end_en = csr_wdata[0];
               default: ;
            endcase
         end
         if (req_if.valid && req_if.ready) begin
            want = next_wait_result(req_if.payload.start_wait, req_if.payload.busy_level);
            expected_q.push_back(pin_active ? pin_value : want);
         end
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_q.size() == 0) begin
               $error("result transaction with no tick outstanding");
               fail_count++;
            end else begin
               want = expected_q.pop_front();
               check_field("wait_done", int'(want.wait_done),
                           int'(rsp_if.payload.wait_done));
               check_field("result_code", int'(want.result_code),
                           int'(rsp_if.payload.result_code));
               check_field("hook_begin", int'(want.hook_begin),
                           int'(rsp_if.payload.hook_begin));
               check_field("hook_end", int'(want.hook_end),
                           int'(rsp_if.payload.hook_end));
               check_field("waiting", int'(want.waiting),
                           int'(rsp_if.payload.waiting));
            end
         end
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   task automatic send_tick(input logic start, input logic level, input logic pinned,
                            input rsp_payload_type want);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      pin_active = pinned;
      pin_value = want;
      req_if.valid <= 1'b1;
      req_if.payload <= '{start_wait: start, busy_level: level};
      do @(posedge clock); while (!req_if.ready);
   endtask

   // hold off new ticks until every outstanding result has been returned
   task automatic wait_results_drained();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_WIDTH-1:0] idx,
                                 input logic [CSR_DATA_WIDTH-1:0] data);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic logic [MS_WIDTH-1:0] pick_ms(int small_max);
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2: return MS_WIDTH'($urandom_range(0, 65535));
         default: return MS_WIDTH'($urandom_range(0, small_max));
      endcase
   endfunction

   initial begin
      int   sent;
      int   n;
      int   block_len;
      int   run;
      logic level;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < $size(DIRECTED_ROWS); i++) begin
         if (DIRECTED_ROWS[i].kind == ROW_CSR) begin
            wait_results_drained();
            write_register(DIRECTED_ROWS[i].csr_idx, DIRECTED_ROWS[i].csr_data);
         end else begin
            send_tick(DIRECTED_ROWS[i].start_wait, DIRECTED_ROWS[i].busy_level,
                      DIRECTED_ROWS[i].pinned, DIRECTED_ROWS[i].want);
         end
      end

      // random waits; settings change between blocks, often with a wait still running
      for (int seg = 0; seg < 3; seg++) begin
         send_idle_pct = (seg == 0) ? 20 : (seg == 1) ? 79 : 0;
         rcv_idle_pct = (seg == 0) ? 79 : (seg == 1) ? 20 : 0;
         sent = 0;
         while (sent < 370) begin
            wait_results_drained();
            write_register(CSR_POLARITY_MODE, CSR_DATA_WIDTH'($urandom_range(0, 3)));
            write_register(CSR_HOOK_THRESHOLD, pick_ms(30));
            write_register(CSR_TOTAL_TIMEOUT, pick_ms(40));
            write_register(CSR_START_WINDOW, pick_ms(15));
            write_register(CSR_PHASE_ONE_LIM, pick_ms(15));
            write_register(CSR_BEGIN_HOOK_EN, CSR_DATA_WIDTH'($urandom_range(0, 1)));
            write_register(CSR_END_HOOK_EN, CSR_DATA_WIDTH'($urandom_range(0, 1)));
            block_len = $urandom_range(20, 80);
            n = 0;
            while (n < block_len) begin
               repeat ($urandom_range(0, 3)) begin
                  send_tick(1'b0, 1'($urandom_range(0, 1)), 1'b0, RSP_QUIET);
               end
               level = 1'($urandom_range(0, 1));
               run = $urandom_range(0, 10);
               send_tick(1'b1, level, 1'b0, RSP_QUIET);
               n++;
               repeat ($urandom_range(1, 40)) begin
                  if (run == 0) begin
                     level = !level;
                     run = $urandom_range(0, 10);
                  end else begin
                     run--;
                  end
                  // occasional restart in the middle of a wait
                  send_tick($urandom_range(0, 49) == 0, level, 1'b0, RSP_QUIET);
                  n++;
               end
            end
            sent += n;
         end
      end

      wait_results_drained();
      repeat (4) @(posedge clock);
      if (fail_count == 0 && expected_q.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
